// File: rtl/core/itoa_pkg.sv
package itoa_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_FIELD  = 64;
  localparam int WIDTH_BITS = 7;
  localparam int DIG_DEPTH  = 16;
  localparam int DIG_IDX    = $clog2(DIG_DEPTH);
  localparam int PC_BITS    = 5;

  // floor(v / 10) == (v * RECIP10) >> 35 for every 32-bit v
  localparam logic [VALUE_BITS-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int                    RECIP_SHIFT = 35;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [1:0] MODE_SDEC = 2'd0;
  localparam logic [1:0] MODE_UDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam logic [1:0] MODE_PTR  = 2'd3;

  typedef struct packed {
    logic [1:0]            mode;
    logic [31:0]           value;
    logic [WIDTH_BITS-1:0] field_width;
    logic                  left_align;
    logic                  zero_pad;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_PREP,
    ACT_HDIG,
    ACT_MUL,
    ACT_DDIG,
    ACT_LEN,
    ACT_PAD,
    ACT_CH0,
    ACT_CHX,
    ACT_MINUS,
    ACT_DIG,
    ACT_SPACE
  } act_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOTACC,
    C_DECMODE,
    C_MORE,
    C_SKIPL,
    C_NOTPTR,
    C_NOTNEG,
    C_CNTMORE,
    C_DIGMORE,
    C_CNTZERO
  } cond_t;

  typedef struct packed {
    act_t               act;
    cond_t              cond;
    logic [PC_BITS-1:0] target;
  } ctrl_t;

  localparam logic [PC_BITS-1:0] PC_IDLE = 5'd0;
  localparam logic [PC_BITS-1:0] PC_PREP = 5'd1;
  localparam logic [PC_BITS-1:0] PC_CHK  = 5'd2;
  localparam logic [PC_BITS-1:0] PC_HDIG = 5'd3;
  localparam logic [PC_BITS-1:0] PC_HEND = 5'd4;
  localparam logic [PC_BITS-1:0] PC_MUL  = 5'd5;
  localparam logic [PC_BITS-1:0] PC_DDIG = 5'd6;
  localparam logic [PC_BITS-1:0] PC_LEN  = 5'd7;
  localparam logic [PC_BITS-1:0] PC_LCHK = 5'd8;
  localparam logic [PC_BITS-1:0] PC_LPAD = 5'd9;
  localparam logic [PC_BITS-1:0] PC_PCHK = 5'd10;
  localparam logic [PC_BITS-1:0] PC_CH0  = 5'd11;
  localparam logic [PC_BITS-1:0] PC_CHX  = 5'd12;
  localparam logic [PC_BITS-1:0] PC_SCHK = 5'd13;
  localparam logic [PC_BITS-1:0] PC_SIGN = 5'd14;
  localparam logic [PC_BITS-1:0] PC_DIGS = 5'd15;
  localparam logic [PC_BITS-1:0] PC_RCHK = 5'd16;
  localparam logic [PC_BITS-1:0] PC_RPAD = 5'd17;
  localparam logic [PC_BITS-1:0] PC_DONE = 5'd18;

  // control store: when the condition holds go to target, else fall through
  function automatic ctrl_t ucode_rom(input logic [PC_BITS-1:0] pc);
    ctrl_t cw;
    cw = '{act: ACT_NONE, cond: C_ALWAYS, target: PC_IDLE};
    case (pc)
      PC_IDLE: cw = '{act: ACT_LOAD,  cond: C_NOTACC,  target: PC_IDLE};
      PC_PREP: cw = '{act: ACT_PREP,  cond: C_NEXT,    target: PC_IDLE};
      PC_CHK:  cw = '{act: ACT_NONE,  cond: C_DECMODE, target: PC_MUL};
      PC_HDIG: cw = '{act: ACT_HDIG,  cond: C_MORE,    target: PC_HDIG};
      PC_HEND: cw = '{act: ACT_NONE,  cond: C_ALWAYS,  target: PC_LEN};
      PC_MUL:  cw = '{act: ACT_MUL,   cond: C_NEXT,    target: PC_IDLE};
      PC_DDIG: cw = '{act: ACT_DDIG,  cond: C_MORE,    target: PC_MUL};
      PC_LEN:  cw = '{act: ACT_LEN,   cond: C_NEXT,    target: PC_IDLE};
      PC_LCHK: cw = '{act: ACT_NONE,  cond: C_SKIPL,   target: PC_PCHK};
      PC_LPAD: cw = '{act: ACT_PAD,   cond: C_CNTMORE, target: PC_LPAD};
      PC_PCHK: cw = '{act: ACT_NONE,  cond: C_NOTPTR,  target: PC_SCHK};
      PC_CH0:  cw = '{act: ACT_CH0,   cond: C_NEXT,    target: PC_IDLE};
      PC_CHX:  cw = '{act: ACT_CHX,   cond: C_NEXT,    target: PC_IDLE};
      PC_SCHK: cw = '{act: ACT_NONE,  cond: C_NOTNEG,  target: PC_DIGS};
      PC_SIGN: cw = '{act: ACT_MINUS, cond: C_NEXT,    target: PC_IDLE};
      PC_DIGS: cw = '{act: ACT_DIG,   cond: C_DIGMORE, target: PC_DIGS};
      PC_RCHK: cw = '{act: ACT_NONE,  cond: C_CNTZERO, target: PC_IDLE};
      PC_RPAD: cw = '{act: ACT_SPACE, cond: C_CNTMORE, target: PC_RPAD};
      PC_DONE: cw = '{act: ACT_NONE,  cond: C_ALWAYS,  target: PC_IDLE};
      default: cw = '{act: ACT_NONE,  cond: C_ALWAYS,  target: PC_IDLE};
    endcase
    return cw;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = CH_LOW_A + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/integer_to_padded_ascii.sv
// channel | ports                           | payload
// in      | in_valid, in_stall, in_item     | mode, value, field_width, left_align, zero_pad
// out     | out_valid, out_stall, out_item  | out_char, last
//
// one item at a time: load, prep and branch, then a reciprocal multiply and a remainder
// step per decimal digit, or a step per hex digit and a step that closes the loop, then
// the length, then one character per cycle while out_stall is low, plus 4 branch steps
// (5 with right padding); the next item is taken only once the sequencer is idle again
// rst_n (synchronous) returns the sequencer to its idle step and empties the output register
// out_stall holds the current emit step; in_stall stays high except in the idle step
module integer_to_padded_ascii (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  itoa_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output itoa_pkg::out_item_t out_item
);
  import itoa_pkg::*;

  logic [PC_BITS-1:0]    pc_r, pc_nxt;
  logic [1:0]            mode_r;
  logic [WIDTH_BITS-1:0] wsat_r;
  logic                  left_r, zpad_r, neg_r;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [2*VALUE_BITS-1:0] prod_r;
  logic [3:0]            dig_r [DIG_DEPTH];
  logic [DIG_IDX-1:0]    ndig_r;
  logic [WIDTH_BITS-1:0] cnt_r;
  logic                  out_valid_r;
  out_item_t             out_item_r;

  ctrl_t                 cw;
  logic                  accept, slot_free, is_emit, hold, cond_ok;
  logic [VALUE_BITS-RECIP_SHIFT+VALUE_BITS-1:0] quot;
  logic [3:0]            new_dig, pop_dig;
  logic [WIDTH_BITS-1:0] text_len, pad_len;
  logic [7:0]            emit_char;
  logic                  emit_last;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (pc_r != PC_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign cw = ucode_rom(pc_r);

  // datapath values
  assign quot    = prod_r[2*VALUE_BITS-1:RECIP_SHIFT];
  assign pop_dig = dig_r[ndig_r - DIG_IDX'(1)];
  assign text_len = WIDTH_BITS'(ndig_r) + WIDTH_BITS'(neg_r)
                  + ((mode_r == MODE_PTR) ? WIDTH_BITS'(2) : WIDTH_BITS'(0));
  assign pad_len = ((mode_r != MODE_PTR) && (wsat_r > text_len)) ? (wsat_r - text_len)
                                                                 : '0;

  always_comb begin
    new_dig = val_r[3:0];
    val_nxt = val_r;
    case (cw.act)
      ACT_HDIG: begin
        new_dig = val_r[3:0];
        val_nxt = val_r >> 4;
      end
      ACT_DDIG: begin
        // remainder modulo 16 is exact since it stays below 10
        new_dig = val_r[3:0] - {quot[0], 3'b0} - {quot[2:0], 1'b0};
        val_nxt = VALUE_BITS'(quot);
      end
      default: begin
        new_dig = val_r[3:0];
        val_nxt = val_r;
      end
    endcase
  end

  always_comb begin
    is_emit   = 1'b0;
    emit_char = CH_SPACE;
    emit_last = 1'b0;
    case (cw.act)
      ACT_PAD: begin
        is_emit   = 1'b1;
        emit_char = zpad_r ? CH_ZERO : CH_SPACE;
      end
      ACT_CH0: begin
        is_emit   = 1'b1;
        emit_char = CH_ZERO;
      end
      ACT_CHX: begin
        is_emit   = 1'b1;
        emit_char = CH_X;
      end
      ACT_MINUS: begin
        is_emit   = 1'b1;
        emit_char = CH_MINUS;
      end
      ACT_DIG: begin
        is_emit   = 1'b1;
        emit_char = digit_char(pop_dig);
        emit_last = (ndig_r == DIG_IDX'(1)) && (cnt_r == '0);
      end
      ACT_SPACE: begin
        is_emit   = 1'b1;
        emit_char = CH_SPACE;
        emit_last = (cnt_r == WIDTH_BITS'(1));
      end
      default: begin
        is_emit   = 1'b0;
        emit_char = CH_SPACE;
        emit_last = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    case (cw.cond)
      C_NEXT:    cond_ok = 1'b0;
      C_ALWAYS:  cond_ok = 1'b1;
      C_NOTACC:  cond_ok = !accept;
      C_DECMODE: cond_ok = !(mode_r inside {MODE_HEX, MODE_PTR});
      C_MORE:    cond_ok = (val_nxt != '0);
      C_SKIPL:   cond_ok = left_r || (cnt_r == '0);
      C_NOTPTR:  cond_ok = (mode_r != MODE_PTR);
      C_NOTNEG:  cond_ok = !neg_r;
      C_CNTMORE: cond_ok = (cnt_r > WIDTH_BITS'(1));
      C_DIGMORE: cond_ok = (ndig_r > DIG_IDX'(1));
      C_CNTZERO: cond_ok = (cnt_r == '0);
      default:   cond_ok = 1'b1;
    endcase
    hold = is_emit && !slot_free;
    if (hold) begin
      pc_nxt = pc_r;
    end else if (cond_ok) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = pc_r + PC_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (is_emit && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_emit && slot_free) begin
      out_item_r.out_char <= emit_char;
      out_item_r.last     <= emit_last;
    end
    case (cw.act)
      ACT_LOAD: begin
        if (accept) begin
          mode_r <= in_item.mode;
          val_r  <= in_item.value[VALUE_BITS-1:0];
          wsat_r <= (in_item.field_width > WIDTH_BITS'(MAX_FIELD))
                    ? WIDTH_BITS'(MAX_FIELD) : in_item.field_width;
          left_r <= in_item.left_align;
          zpad_r <= in_item.zero_pad;
        end
      end
      ACT_PREP: begin
        neg_r  <= (mode_r == MODE_SDEC) && val_r[VALUE_BITS-1];
        ndig_r <= '0;
        if ((mode_r == MODE_SDEC) && val_r[VALUE_BITS-1]) begin
          val_r <= ~val_r + VALUE_BITS'(1);
        end
      end
      ACT_MUL: begin
        prod_r <= (2*VALUE_BITS)'(val_r) * (2*VALUE_BITS)'(RECIP10);
      end
      ACT_HDIG, ACT_DDIG: begin
        dig_r[ndig_r] <= new_dig;
        ndig_r        <= ndig_r + DIG_IDX'(1);
        val_r         <= val_nxt;
      end
      ACT_LEN: begin
        cnt_r <= pad_len;
      end
      ACT_PAD, ACT_SPACE: begin
        if (slot_free) begin
          cnt_r <= cnt_r - WIDTH_BITS'(1);
        end
      end
      ACT_DIG: begin
        if (slot_free) begin
          ndig_r <= ndig_r - DIG_IDX'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/itoa_checker.sv
module itoa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input itoa_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input itoa_pkg::out_item_t out_item
);
  import itoa_pkg::*;

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  // the block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // when idle, only the final character of the previous field may still wait
  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && out_valid |-> out_item.last)
    else $error("idle with an unfinished field");

  // a new item never starts over a pending non-final character
  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !out_valid || out_item.last)
    else $error("item accepted mid-field");

endmodule

bind integer_to_padded_ascii itoa_checker u_itoa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// File: sim/tb_integer_to_padded_ascii.sv
module tb_integer_to_padded_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  import itoa_pkg::*;

  localparam int N_DIRECTED = 24;
  localparam int N_RANDOM   = 300;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // characters still owed by the block, oldest first
  out_item_t pending_chars[$];
  // fixed text for the item being offered, empty means use the formatter
  string     typed_text = "";
  bit        quiet = 1'b0;
  int        mismatch_count = 0;

  // directed items, and the text each should print where it is obvious
  in_item_t dir_items [N_DIRECTED] = '{
    '{MODE_SDEC, 32'h0000_0000, 7'd0,   1'b0, 1'b0},
    '{MODE_SDEC, 32'h8000_0000, 7'd0,   1'b0, 1'b0},
    '{MODE_SDEC, 32'h7fff_ffff, 7'd0,   1'b0, 1'b0},
    '{MODE_SDEC, 32'hffff_ffff, 7'd0,   1'b0, 1'b0},
    '{MODE_UDEC, 32'hffff_ffff, 7'd0,   1'b0, 1'b0},
    '{MODE_UDEC, 32'h0000_0000, 7'd0,   1'b0, 1'b1},
    '{MODE_HEX,  32'hdead_beef, 7'd0,   1'b0, 1'b0},
    '{MODE_HEX,  32'h0000_0000, 7'd0,   1'b0, 1'b0},
    '{MODE_PTR,  32'h0000_0000, 7'd0,   1'b0, 1'b0},
    '{MODE_PTR,  32'hffff_ffff, 7'd20,  1'b1, 1'b1},
    '{MODE_PTR,  32'h0000_1234, 7'd127, 1'b0, 1'b1},
    '{MODE_SDEC, 32'hffff_fffb, 7'd4,   1'b0, 1'b1},
    '{MODE_SDEC, 32'hffff_fffb, 7'd4,   1'b0, 1'b0},
    '{MODE_SDEC, 32'hffff_fffb, 7'd4,   1'b1, 1'b1},
    '{MODE_UDEC, 32'd42,        7'd2,   1'b0, 1'b1},
    '{MODE_UDEC, 32'd7,         7'd1,   1'b1, 1'b0},
    '{MODE_HEX,  32'h0f0f_0f0f, 7'd10,  1'b0, 1'b0},
    '{MODE_SDEC, 32'd10,        7'd3,   1'b0, 1'b0},
    '{MODE_UDEC, 32'd1000000000, 7'd0,  1'b0, 1'b0},
    '{MODE_HEX,  32'h0000_00ab, 7'd64,  1'b0, 1'b1},
    '{MODE_UDEC, 32'd123,       7'd127, 1'b1, 1'b0},
    '{MODE_UDEC, 32'd1,         7'd65,  1'b0, 1'b0},
    '{MODE_SDEC, 32'h8000_0000, 7'd100, 1'b0, 1'b1},
    '{MODE_HEX,  32'hffff_ffff, 7'd9,   1'b1, 1'b1}
  };

  string dir_texts [N_DIRECTED] = '{
    "0", "-2147483648", "2147483647", "-1", "4294967295", "0", "deadbeef", "0",
    "0x0", "0xffffffff", "0x1234", "00-5", "  -5", "-5  ", "42", "7",
    "   f0f0f0f", " 10", "1000000000", "", "", "", "", ""
  };

  integer_to_padded_ascii i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // printf-style field for one item
  function automatic string format_field(input in_item_t it);
    logic [31:0] mag;
    string       body;
    string       fill;
    int          w;
    int          npad;
    mag  = it.value;
    body = "";
    fill = "";
    if (it.mode == MODE_PTR) begin
      body = "0x";
    end
    if (it.mode == MODE_SDEC && mag[31]) begin
      body = {body, "-"};
      // the most negative value stays 0x8000_0000, read as unsigned
      mag  = 32'h0 - mag;
    end
    if (it.mode == MODE_HEX || it.mode == MODE_PTR) begin
      body = {body, $sformatf("%0h", mag)};
    end else begin
      body = {body, $sformatf("%0d", mag)};
    end
    w    = (it.field_width > MAX_FIELD) ? MAX_FIELD : int'(it.field_width);
    npad = (it.mode != MODE_PTR && w > body.len()) ? w - body.len() : 0;
    for (int i = 0; i < npad; i++) begin
      fill = {fill, (it.zero_pad && !it.left_align) ? "0" : " "};
    end
    return it.left_align ? {body, fill} : {fill, body};
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("tb: mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    string     text;
    out_item_t want;
    if (rst_n && in_valid && !in_stall) begin
      text = (typed_text.len() != 0) ? typed_text : format_field(in_item);
      for (int i = 0; i < text.len(); i++) begin
        pending_chars.push_back('{out_char: text[i], last: (i == text.len() - 1)});
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch($sformatf("unexpected char 8'h%02h", out_item.out_char));
      end else begin
        want = pending_chars.pop_front();
        if (out_item.out_char !== want.out_char) begin
          flag_mismatch($sformatf("char 8'h%02h, expected 8'h%02h",
                                  out_item.out_char, want.out_char));
        end
        if (out_item.last !== want.last) begin
          flag_mismatch($sformatf("last %b, expected %b on char 8'h%02h",
                                  out_item.last, want.last, want.out_char));
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 19);
  end

  task automatic send_item(input in_item_t it, input string text);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_item    <= it;
    typed_text = text;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    it.mode = 2'($urandom_range(3));
    case ($urandom_range(3))
      0: it.value = $urandom;
      1: it.value = 32'($urandom_range(999));
      2: it.value = 32'h0 - 32'($urandom_range(1000));
      default: it.value = $urandom >> $urandom_range(31);
    endcase
    // mostly short fields, now and then the wide ones
    if ($urandom_range(99) < 10) begin
      it.field_width = 7'($urandom_range(127));
    end else begin
      it.field_width = 7'($urandom_range(16));
    end
    it.left_align = 1'($urandom_range(1));
    it.zero_pad   = 1'($urandom_range(1));
    return it;
  endfunction

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(dir_items[i], dir_texts[i]);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      // a long run with no gaps on either side
      quiet = (i >= 120 && i < 200);
      send_item(random_item(), "");
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
